/* hdl/hbh_mpl_pkg.sv */
// shared types, constants and helpers for the hop-by-hop mpl option parser
`timescale 1ns / 1ps

package hbh_mpl_pkg;

  // one packet byte as it arrives
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // one verdict per packet
  typedef struct packed {
    logic        verdict;
    logic [2:0]  drop_reason;
    logic [4:0]  seed_length;
    logic [63:0] seed_upper;
    logic [63:0] seed_lower;
    logic [7:0]  sequence_number;
    logic        largest_flag;
    logic [7:0]  option_length;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IPV6,
    PH_HBH_NEXT,
    PH_HBH_LEN,
    PH_TYPE,
    PH_OPTLEN,
    PH_SKIP,
    PH_MPL,
    PH_DECIDED
  } phase_t;

  localparam logic [2:0] RSN_NONE      = 3'd0;
  localparam logic [2:0] RSN_NO_HBH    = 3'd1;
  localparam logic [2:0] RSN_TRUNCATED = 3'd2;
  localparam logic [2:0] RSN_V_FLAG    = 3'd3;
  localparam logic [2:0] RSN_NO_MPL    = 3'd4;

  localparam logic [7:0]  OPT_MPL      = 8'h6D;
  localparam int unsigned FLAG_V_BIT   = 4;
  localparam int unsigned FLAG_M_BIT   = 5;
  localparam logic [15:0] POS_NEXT_HDR = 16'd6;
  localparam logic [15:0] POS_IP6_LAST = 16'd39;
  localparam logic [8:0]  MPL_FIXED    = 9'd2;

  // seed id length from the s field (flags bits 7..6)
  function automatic logic [4:0] seed_len(input logic [7:0] flags);
    logic [4:0] len;
    begin
      case (flags[7:6])
        2'd0:    len = 5'd0;
        2'd1:    len = 5'd2;
        2'd2:    len = 5'd8;
        default: len = 5'd16;
      endcase
      return len;
    end
  endfunction

endpackage

/* hdl/hbh_mpl_parser.sv */
// per-byte parse state and next-state logic of the hop-by-hop option walk
`timescale 1ns / 1ps

module hbh_mpl_parser
  import hbh_mpl_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output logic      done,
  output out_item_t result
);

  localparam logic [15:0] POS_LIMIT = 16'(MAX_PACKET_BYTES);

  phase_t       phase, phase_next;
  logic [15:0]  pos, pos_next;
  logic [11:0]  hbl, hbl_next;
  logic [7:0]   obl, obl_next;
  logic [7:0]   opt_type, opt_type_next;
  logic [7:0]   flags, flags_next;
  logic [127:0] seed, seed_next;
  logic [7:0]   seq, seq_next;
  logic [2:0]   pend, pend_next;
  logic [7:0]   mpl_len, mpl_len_next;

  logic        parse_en;
  logic        hbl_live;
  logic [11:0] hbl_dec;
  logic [7:0]  obl_dec;
  logic [7:0]  idx;
  logic [4:0]  slen_cur;
  logic [4:0]  slen_new;
  logic [7:0]  b;
  logic        decide;
  logic [2:0]  reason;
  logic [2:0]  final_reason;

  assign b        = item.data_byte;
  assign parse_en = step && (pos < POS_LIMIT);
  assign hbl_live = (hbl != 12'd0);
  assign hbl_dec  = hbl - 12'd1;
  assign obl_dec  = obl - 8'd1;
  assign idx      = mpl_len - obl;
  assign slen_cur = seed_len(flags);
  assign slen_new = seed_len(b);

  // next phase and the decision taken on this byte
  always_comb begin
    phase_next = phase;
    decide     = 1'b0;
    reason     = pend;
    if (parse_en) begin
      unique case (phase)
        PH_IPV6: begin
          if (pos == POS_NEXT_HDR && b != 8'd0) begin
            decide = 1'b1;
            reason = RSN_NO_HBH;
          end else if (pos == POS_IP6_LAST) begin
            phase_next = PH_HBH_NEXT;
          end
        end
        PH_HBH_NEXT: phase_next = PH_HBH_LEN;
        PH_HBH_LEN:  phase_next = PH_TYPE;
        PH_TYPE: begin
          if (hbl_live) begin
            if (b == 8'd0) begin
              if (hbl_dec == 12'd0) begin
                decide = 1'b1;
                reason = RSN_NO_MPL;
              end
            end else if (hbl_dec == 12'd0) begin
              decide = 1'b1;
              reason = RSN_TRUNCATED;
            end else begin
              phase_next = PH_OPTLEN;
            end
          end
        end
        PH_OPTLEN: begin
          if (hbl_live) begin
            if ({4'd0, b} > hbl_dec) begin
              decide = 1'b1;
              reason = RSN_TRUNCATED;
            end else if (opt_type == OPT_MPL) begin
              if (b == 8'd0) begin
                decide = 1'b1;
                reason = RSN_TRUNCATED;
              end else begin
                phase_next = PH_MPL;
              end
            end else if (b == 8'd0) begin
              if (hbl_dec == 12'd0) begin
                decide = 1'b1;
                reason = RSN_NO_MPL;
              end else begin
                phase_next = PH_TYPE;
              end
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (hbl_live && obl_dec == 8'd0) begin
            if (hbl_dec == 12'd0) begin
              decide = 1'b1;
              reason = RSN_NO_MPL;
            end else begin
              phase_next = PH_TYPE;
            end
          end
        end
        PH_MPL: begin
          if (hbl_live) begin
            if (idx == 8'd0) begin
              if (b[FLAG_V_BIT]) begin
                decide = 1'b1;
                reason = RSN_V_FLAG;
              end else if ({1'b0, mpl_len} < MPL_FIXED + {4'd0, slen_new}) begin
                decide = 1'b1;
                reason = RSN_TRUNCATED;
              end
            end else if (idx == 8'd1) begin
              if (slen_cur == 5'd0) begin
                decide = 1'b1;
                reason = RSN_NONE;
              end
            end else if (idx == 8'd1 + {3'd0, slen_cur}) begin
              decide = 1'b1;
              reason = RSN_NONE;
            end
          end
        end
        PH_DECIDED: ;
        default: ;
      endcase
      if (decide) begin
        phase_next = PH_DECIDED;
      end
    end
  end

  // datapath registers
  always_comb begin
    pos_next      = pos;
    hbl_next      = hbl;
    obl_next      = obl;
    opt_type_next = opt_type;
    flags_next    = flags;
    seed_next     = seed;
    seq_next      = seq;
    mpl_len_next  = mpl_len;
    pend_next     = decide ? reason : pend;
    if (parse_en) begin
      pos_next = pos + 16'd1;
      if (phase == PH_HBH_LEN) begin
        hbl_next = {1'b0, b, 3'b110};
      end else if (phase != PH_IPV6 && phase != PH_HBH_NEXT && hbl_live) begin
        hbl_next = hbl_dec;
        case (phase)
          PH_TYPE: begin
            if (b != 8'd0) begin
              opt_type_next = b;
            end
          end
          PH_OPTLEN: begin
            obl_next = b;
            if ({4'd0, b} <= hbl_dec && opt_type == OPT_MPL) begin
              mpl_len_next = b;
            end
          end
          PH_SKIP: obl_next = obl_dec;
          PH_MPL: begin
            obl_next = obl_dec;
            if (idx == 8'd0) begin
              flags_next = b;
            end else if (idx == 8'd1) begin
              seq_next = b;
            end else begin
              seed_next = {seed[119:0], b};
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase    <= PH_IPV6;
      pos      <= '0;
      hbl      <= '0;
      obl      <= '0;
      opt_type <= '0;
      flags    <= '0;
      seed     <= '0;
      seq      <= '0;
      pend     <= RSN_NO_MPL;
      mpl_len  <= '0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      hbl      <= hbl_next;
      obl      <= obl_next;
      opt_type <= opt_type_next;
      flags    <= flags_next;
      seed     <= seed_next;
      seq      <= seq_next;
      pend     <= pend_next;
      mpl_len  <= mpl_len_next;
    end
  end

  // verdict from the state as it stands after the final byte
  always_comb begin
    if (pend_next == RSN_NO_HBH) begin
      final_reason = RSN_NO_HBH;
    end else if (phase_next == PH_IPV6 || phase_next == PH_HBH_NEXT ||
                 phase_next == PH_HBH_LEN || hbl_next != 12'd0) begin
      final_reason = RSN_TRUNCATED;
    end else begin
      final_reason = pend_next;
    end
  end

  assign done = step && item.last_byte;

  always_comb begin
    result             = '0;
    result.verdict     = (final_reason != RSN_NONE);
    result.drop_reason = final_reason;
    if (final_reason == RSN_NONE) begin
      result.seed_length     = seed_len(flags_next);
      result.seed_upper      = seed_next[127:64];
      result.seed_lower      = seed_next[63:0];
      result.sequence_number = seq_next;
      result.largest_flag    = flags_next[FLAG_M_BIT];
      result.option_length   = mpl_len_next;
    end
  end

endmodule

/* hdl/ipv6_hbh_mpl_option_parser_top.sv */
// ipv6 hop-by-hop mpl option parser: byte stream in, one verdict per packet out
//
// pkt channel: one packet byte per transfer, starting at the first ipv6
// header byte, last_byte set on the final byte of the packet.
// res channel: one verdict transfer per packet, seed id, sequence number,
// m flag and option length filled in only when the verdict is success.
// a byte is taken every cycle while pkt_ready is high; the parse state is updated
// in the cycle of the transfer and the verdict of a last byte sits in the result
// register in the cycle after, so throughput is one byte per cycle while no
// verdict stalls.
// non-last bytes produce no result transfer.
// pkt_ready drops only while a verdict waits in the result register and
// res_ready is low; the parse state holds until the stall clears.
// reset (rst, synchronous) empties the result register and returns the
// parser to the start of a packet; the parser also restarts after each
// last byte. bytes past MAX_PACKET_BYTES are counted no further and ignored.
`timescale 1ns / 1ps

module ipv6_hbh_mpl_option_parser_top
  import hbh_mpl_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pkt_valid,
  output logic      pkt_ready,
  input  in_item_t  pkt,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  logic      step;
  logic      done;
  out_item_t result;

  assign pkt_ready = !res_valid || res_ready;
  assign step      = pkt_valid && pkt_ready;

  hbh_mpl_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (pkt),
    .done  (done),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pkt_ready) begin
      res_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res <= result;
    end
  end

  a_verdict_matches_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.verdict == (res.drop_reason != RSN_NONE)))
    else $error("verdict and reason disagree");

  a_drop_fields_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.verdict |-> (res.seed_length == 5'd0 && res.option_length == 8'd0 &&
                                  res.sequence_number == 8'd0 && !res.largest_flag))
    else $error("dropped packet carries option fields");

  a_seed_length_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.verdict |-> (res.seed_length == 5'd0 || res.seed_length == 5'd2 ||
                                   res.seed_length == 5'd8 || res.seed_length == 5'd16))
    else $error("illegal seed length");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    step && pkt.last_byte |=> res_valid)
    else $error("last byte without verdict");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !pkt_ready)
    else $error("input taken while verdict stalled");

endmodule
